### hw/rtl/lcgfpc_pkg.sv
// Package for the LCG full-period checker: shared types and constants.
// Used by the divider and the top level; depends on nothing.
`timescale 1ns / 1ps

package lcgfpc_pkg;

  // Width of every configuration register and of the write data port.
  localparam int CFG_W = 32;
  localparam int CFG_ADDR_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_MULTIPLIER = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INCREMENT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MODULUS    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SEED       = 2'd3;

  // Generator kinds carried by the request.
  localparam logic KIND_MIXED = 1'b0;

  // Residues mod 8 that give full period for a multiplicative generator.
  localparam logic [2:0] MUL_RES_A = 3'd3;
  localparam logic [2:0] MUL_RES_B = 3'd5;

  // Residue mod 4 the multiplier needs when 4 divides the modulus.
  localparam logic [1:0] MIX_RES_4 = 2'd1;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### hw/rtl/lcgfpc_div.sv
// Shared restoring divider: one quotient bit per cycle, WIDTH iterations after the load.
// Depends on lcgfpc_pkg for the status struct.
`timescale 1ns / 1ps

module lcgfpc_div
  import lcgfpc_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output div_sts_t         sts,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] dsr_r, dsr_nxt;

  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;

  // Partial remainder shifted by one bit, then the trial subtraction.
  assign shifted = {rem_r, quo_r[WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      cnt_nxt = CNT_W'(WIDTH);
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!diff[WIDTH+1]) begin
        rem_nxt = diff[WIDTH-1:0];
        quo_nxt = {quo_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[WIDTH-1:0];
        quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
      end
      if (cnt_r == CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts.busy  = (cnt_r != '0);
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  // The done pulse follows the last iteration and nothing else.
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(cnt_r) == CNT_W'(1))
    else $error("divider done without a final iteration");

  // A finished division leaves a remainder below a nonzero divisor.
  a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && dsr_r != '0 |-> rem_r < dsr_r)
    else $error("divider remainder not below divisor");

  // Done is never raised while iterations are still pending.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> cnt_r == '0)
    else $error("divider done while still busy");

endmodule

### hw/rtl/lcg_full_period_checker.sv
// Top level of the LCG full-period checker: configuration registers, sequencer, handshakes.
// Depends on lcgfpc_pkg and instantiates the shared divider lcgfpc_div.
`timescale 1ns / 1ps

// Each request transfer asks whether the generator held in the configuration
// registers (multiplier, increment, modulus, seed, masked to WIDTH bits) has
// maximal period, and yields exactly one result transfer. A multiplicative
// request is settled by a few bit tests, without any division. A mixed
// request with a zero modulus, or with 4 dividing the modulus and a
// multiplier that is not 1 mod 4, is rejected without any division as well.
// Any other mixed request runs the Hull-Dobell test on one shared restoring
// divider. The number of divisions depends on the data: the Euclid steps of
// gcd(increment, modulus), one trial division for every candidate factor p
// up to the first with p*p above the remaining cofactor, one multiplier
// residue per prime factor found and one strip division per power of that
// prime dividing the modulus, and one final residue check for a leftover
// prime cofactor; a failing residue ends the check early. Such a request
// ends after one division when the modulus (not 1) divides the increment,
// needs two for a unit modulus, and up to about 2^(WIDTH/2) divisions for
// a large prime modulus. The input side is ready only while the sequencer
// is idle; a finished verdict sits in the output register, so a new request
// can be taken while the previous result still waits for its transfer.
// Configuration writes must only be made while the block is idle.

module lcg_full_period_checker
  import lcgfpc_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  // Request channel.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_generator_kind,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_full_period,
  output logic                  out_decided
);

  // Number of configuration bits that reach the WIDTH-bit datapath.
  localparam int MINW = (WIDTH < CFG_W) ? WIDTH : CFG_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_GCD   = 7'b0000010,
    S_TRIAL = 7'b0000100,
    S_ACHK  = 7'b0001000,
    S_STRIP = 7'b0010000,
    S_TAIL  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  // Configuration registers.
  logic [CFG_W-1:0] mult_r, mult_nxt;
  logic [CFG_W-1:0] incr_r, incr_nxt;
  logic [CFG_W-1:0] mod_r,  mod_nxt;
  logic [CFG_W-1:0] seed_r, seed_nxt;

  // Sequencer state.
  state_t           state_r, state_nxt;
  logic [WIDTH-1:0] gcd_y_r, gcd_y_nxt;   // divisor of the current Euclid step
  logic [WIDTH-1:0] mm_r,    mm_nxt;      // modulus with found factors stripped
  logic [WIDTH-1:0] p_r,     p_nxt;       // current trial factor
  logic             full_r,  full_nxt;
  logic             dec_r,   dec_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic             out_full_r,  out_full_nxt;
  logic             out_dec_r,   out_dec_nxt;

  // Divider interface.
  logic             div_start;
  logic [WIDTH-1:0] div_dividend;
  logic [WIDTH-1:0] div_divisor;
  div_sts_t         div_sts;
  logic [WIDTH-1:0] div_quo;
  logic [WIDTH-1:0] div_rem;

  // Operands seen by the datapath, masked or zero-extended to WIDTH bits.
  logic [WIDTH-1:0] a_w, c_w, m_w, x0_w;
  logic             m_pow2;
  logic             in_xfer;

  always_comb begin
    a_w  = '0;
    c_w  = '0;
    m_w  = '0;
    x0_w = '0;
    a_w[MINW-1:0]  = mult_r[MINW-1:0];
    c_w[MINW-1:0]  = incr_r[MINW-1:0];
    m_w[MINW-1:0]  = mod_r[MINW-1:0];
    x0_w[MINW-1:0] = seed_r[MINW-1:0];
  end

  // A power of two has a single bit set.
  assign m_pow2  = (m_w != '0) && ((m_w & (m_w - 1'b1)) == '0);
  assign in_xfer = in_valid && in_ready;

  // Configuration writes.
  always_comb begin
    mult_nxt = mult_r;
    incr_nxt = incr_r;
    mod_nxt  = mod_r;
    seed_nxt = seed_r;
    if (cfg_wr_en) begin
      case (cfg_addr)
        REG_MULTIPLIER: mult_nxt = cfg_wr_data;
        REG_INCREMENT:  incr_nxt = cfg_wr_data;
        REG_MODULUS:    mod_nxt  = cfg_wr_data;
        REG_SEED:       seed_nxt = cfg_wr_data;
        default:        mult_nxt = mult_r;
      endcase
    end
  end

  // Sequencer. Every computing state waits for the divider's done pulse,
  // acts on its quotient and remainder, and in the same cycle launches the
  // next division when one is needed.
  always_comb begin
    state_nxt    = state_r;
    gcd_y_nxt    = gcd_y_r;
    mm_nxt       = mm_r;
    p_nxt        = p_r;
    full_nxt     = full_r;
    dec_nxt      = dec_r;
    div_start    = 1'b0;
    div_dividend = mm_r;
    div_divisor  = p_r;

    out_valid_nxt = out_valid_r && !out_ready;
    out_full_nxt  = out_full_r;
    out_dec_nxt   = out_dec_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          dec_nxt  = 1'b1;
          full_nxt = 1'b0;
          if (in_generator_kind != KIND_MIXED) begin
            // Multiplicative: judged only for a power-of-two modulus.
            dec_nxt   = m_pow2;
            full_nxt  = m_pow2 && a_w[0] && x0_w[0] &&
                        (a_w[2:0] inside {MUL_RES_A, MUL_RES_B});
            state_nxt = S_FIN;
          end else if (m_w == '0 ||
                       (m_w[1:0] == 2'b00 && a_w[1:0] != MIX_RES_4)) begin
            // Zero modulus, or 4 divides the modulus and the multiplier
            // is not 1 mod 4: rejected without any division.
            state_nxt = S_FIN;
          end else begin
            // First Euclid step: increment mod modulus.
            gcd_y_nxt    = m_w;
            div_start    = 1'b1;
            div_dividend = c_w;
            div_divisor  = m_w;
            state_nxt    = S_GCD;
          end
        end
      end

      S_GCD: begin
        if (div_sts.done) begin
          if (div_rem == '0) begin
            if (gcd_y_r != WIDTH'(1)) begin
              state_nxt = S_FIN;
            end else begin
              // Increment and modulus are coprime; start trial division.
              mm_nxt       = m_w;
              p_nxt        = WIDTH'(2);
              div_start    = 1'b1;
              div_dividend = m_w;
              div_divisor  = WIDTH'(2);
              state_nxt    = S_TRIAL;
            end
          end else begin
            gcd_y_nxt    = div_rem;
            div_start    = 1'b1;
            div_dividend = gcd_y_r;
            div_divisor  = div_rem;
          end
        end
      end

      S_TRIAL: begin
        if (div_sts.done) begin
          if (p_r > div_quo) begin
            // No factor up to the square root is left: what remains is
            // either one or a prime.
            if (mm_r > WIDTH'(1)) begin
              div_start    = 1'b1;
              div_dividend = a_w;
              div_divisor  = mm_r;
              state_nxt    = S_TAIL;
            end else begin
              full_nxt  = 1'b1;
              state_nxt = S_FIN;
            end
          end else if (div_rem == '0) begin
            // p is a prime factor: strip it once and check the multiplier.
            mm_nxt       = div_quo;
            div_start    = 1'b1;
            div_dividend = a_w;
            div_divisor  = p_r;
            state_nxt    = S_ACHK;
          end else begin
            p_nxt        = p_r + 1'b1;
            div_start    = 1'b1;
            div_dividend = mm_r;
            div_divisor  = p_r + 1'b1;
          end
        end
      end

      S_ACHK: begin
        if (div_sts.done) begin
          if (div_rem != WIDTH'(1)) begin
            state_nxt = S_FIN;
          end else begin
            div_start    = 1'b1;
            div_dividend = mm_r;
            div_divisor  = p_r;
            state_nxt    = S_STRIP;
          end
        end
      end

      S_STRIP: begin
        if (div_sts.done) begin
          if (div_rem == '0) begin
            mm_nxt       = div_quo;
            div_start    = 1'b1;
            div_dividend = div_quo;
            div_divisor  = p_r;
          end else begin
            p_nxt        = p_r + 1'b1;
            div_start    = 1'b1;
            div_dividend = mm_r;
            div_divisor  = p_r + 1'b1;
            state_nxt    = S_TRIAL;
          end
        end
      end

      S_TAIL: begin
        if (div_sts.done) begin
          full_nxt  = (div_rem == WIDTH'(1));
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        // Hand the verdict to the output register once it is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_full_nxt  = full_r;
          out_dec_nxt   = dec_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r      <= CFG_W'(1);
      incr_r      <= '0;
      mod_r       <= CFG_W'(1);
      seed_r      <= '0;
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      mult_r      <= mult_nxt;
      incr_r      <= incr_nxt;
      mod_r       <= mod_nxt;
      seed_r      <= seed_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gcd_y_r    <= gcd_y_nxt;
    mm_r       <= mm_nxt;
    p_r        <= p_nxt;
    full_r     <= full_nxt;
    dec_r      <= dec_nxt;
    out_full_r <= out_full_nxt;
    out_dec_r  <= out_dec_nxt;
  end

  lcgfpc_div #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .sts       (div_sts),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_full_period = out_full_r;
  assign out_decided     = out_dec_r;

  // A new division is only launched on an idle divider.
  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("division launched while divider busy");

  // While the sequencer is idle no division is in flight.
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !div_sts.busy && !div_sts.done)
    else $error("divider active while sequencer idle");

  // An undecided verdict never claims full period.
  a_undecided_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_dec_r |-> !out_full_r)
    else $error("undecided result flagged as full period");

  // A verdict is loaded into the output register only from the final state.
  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result produced outside the final state");

endmodule

### dv/tb_top.sv
// Self-checking bench for lcg_full_period_checker: a directed table, then randomized settings.
// Depends on lcgfpc_pkg and the checker RTL; verdicts are compared with the table or a predictor.
`timescale 1ns / 1ps

module tb_top;
  import lcgfpc_pkg::*;

  // The package names only the mixed kind; the other value of the request bit is multiplicative.
  localparam logic KIND_MULT = ~KIND_MIXED;

  localparam int RANDOM_REQUESTS = 450;
  // The slowest legal request here is a mixed check of 2^32-1 with a passing multiplier:
  // a few hundred divisions. The limit leaves a wide margin over that.
  localparam int WATCHDOG_LIMIT  = 100000;
  localparam int DRAIN_CYCLES    = 64;

  typedef struct packed {
    logic full_period;
    logic decided;
  } verdict_t;

  // One row of the directed table. When typed is clear, want is ignored and the
  // predictor supplies the expectation instead.
  typedef struct packed {
    bit           wr;
    bit [CFG_W-1:0] mult;
    bit [CFG_W-1:0] incr;
    bit [CFG_W-1:0] modv;
    bit [CFG_W-1:0] seedv;
    logic         kind;
    bit           typed;
    verdict_t     want;
  } dir_row_t;

  // Rows without wr reuse the registers left by the row above them. The first two
  // rows run on the values that reset leaves in the registers.
  localparam dir_row_t DIRECTED [25] = '{
    // Reset state, mixed: unit modulus has no prime factors, so full period.
    '{1'b0, 32'd1, 32'd0, 32'd1, 32'd0, KIND_MIXED, 1'b1, '{1'b1, 1'b1}},
    // Reset state, multiplicative: modulus 1 is a power of two, multiplier 1 fails mod 8.
    '{1'b0, 32'd1, 32'd0, 32'd1, 32'd0, KIND_MULT, 1'b1, '{1'b0, 1'b1}},
    // Zero modulus: a mixed check rejects, a multiplicative one is undecided.
    '{1'b1, 32'd5, 32'd1, 32'd0, 32'd1, KIND_MIXED, 1'b1, '{1'b0, 1'b1}},
    '{1'b0, 32'd5, 32'd1, 32'd0, 32'd1, KIND_MULT, 1'b1, '{1'b0, 1'b0}},
    // All-ones registers with unit modulus.
    '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, KIND_MIXED, 1'b1,
      '{1'b1, 1'b1}},
    '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, KIND_MULT, 1'b1,
      '{1'b0, 1'b1}},
    // The largest power-of-two modulus: multiplicative checks and one mixed check.
    '{1'b1, 32'd0, 32'd0, 32'h8000_0000, 32'd0, KIND_MULT, 1'b1, '{1'b0, 1'b1}},
    '{1'b1, 32'd5, 32'd0, 32'h8000_0000, 32'd1, KIND_MULT, 1'b1, '{1'b1, 1'b1}},
    '{1'b1, 32'd3, 32'd0, 32'h8000_0000, 32'd0, KIND_MULT, 1'b1, '{1'b0, 1'b1}},
    '{1'b1, 32'hFFFF_FFFD, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, KIND_MULT, 1'b1,
      '{1'b1, 1'b1}},
    '{1'b0, 32'hFFFF_FFFD, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, KIND_MIXED, 1'b1,
      '{1'b1, 1'b1}},
    '{1'b1, 32'd7, 32'd1, 32'h8000_0000, 32'd1, KIND_MULT, 1'b1, '{1'b0, 1'b1}},
    // Multiplicative with a modulus that is not a power of two: not judged.
    '{1'b1, 32'd5, 32'd1, 32'd6, 32'd1, KIND_MULT, 1'b1, '{1'b0, 1'b0}},
    '{1'b1, 32'd5, 32'd1, 32'hFFFF_FFFF, 32'd1, KIND_MULT, 1'b1, '{1'b0, 1'b0}},
    // The largest modulus, mixed: 3*5*17*257*65537.
    '{1'b0, 32'd5, 32'd1, 32'hFFFF_FFFF, 32'd1, KIND_MIXED, 1'b0, '{1'b0, 1'b0}},
    '{1'b1, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'd0, KIND_MIXED, 1'b0, '{1'b0, 1'b0}},
    '{1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, KIND_MIXED, 1'b0, '{1'b0, 1'b0}},
    // Modulus 16: pass, fail on the mod-4 rule, fail on the gcd.
    '{1'b1, 32'd5, 32'd1, 32'd16, 32'd0, KIND_MIXED, 1'b0, '{1'b0, 1'b0}},
    '{1'b1, 32'd3, 32'd1, 32'd16, 32'd0, KIND_MIXED, 1'b0, '{1'b0, 1'b0}},
    '{1'b1, 32'd5, 32'd2, 32'd16, 32'd0, KIND_MIXED, 1'b0, '{1'b0, 1'b0}},
    // Two primes with 4 dividing the modulus, and an odd prime power.
    '{1'b1, 32'd13, 32'd5, 32'd12, 32'd0, KIND_MIXED, 1'b0, '{1'b0, 1'b0}},
    '{1'b1, 32'd4, 32'd2, 32'd9, 32'd0, KIND_MIXED, 1'b0, '{1'b0, 1'b0}},
    // A prime cofactor left over after trial division: fail, then pass.
    '{1'b1, 32'd3, 32'd1, 32'd14, 32'd0, KIND_MIXED, 1'b0, '{1'b0, 1'b0}},
    '{1'b1, 32'd15, 32'd1, 32'd14, 32'd0, KIND_MIXED, 1'b0, '{1'b0, 1'b0}},
    // Zero multiplier against the smallest prime modulus.
    '{1'b1, 32'd0, 32'd1, 32'd2, 32'd0, KIND_MIXED, 1'b0, '{1'b0, 1'b0}}
  };

  logic                  clk               = 1'b0;
  logic                  rst_n             = 1'b0;
  logic                  cfg_wr_en         = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr          = REG_MULTIPLIER;
  logic [CFG_W-1:0]      cfg_wr_data       = '0;
  logic                  in_valid          = 1'b0;
  logic                  in_ready;
  logic                  in_generator_kind = KIND_MIXED;
  logic                  out_valid;
  logic                  out_ready         = 1'b0;
  logic                  out_full_period;
  logic                  out_decided;

  // Copy of the configuration registers as the bench last wrote them.
  bit [CFG_W-1:0] cur_mult = 32'd1;
  bit [CFG_W-1:0] cur_incr = 32'd0;
  bit [CFG_W-1:0] cur_mod  = 32'd1;
  bit [CFG_W-1:0] cur_seed = 32'd0;

  // Verdicts owed by the block, oldest first.
  verdict_t verdicts_pending [$];

  // When set, neither side idles: back-to-back transfers on both channels.
  bit steady = 1'b0;

  int failures       = 0;
  int requests_sent  = 0;
  int mixed_sent     = 0;
  int settings_used  = 0;
  int full_seen      = 0;
  int undecided_seen = 0;
  int quiet_cycles   = 0;

  lcg_full_period_checker DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_addr         (cfg_addr),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_generator_kind(in_generator_kind),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_full_period  (out_full_period),
    .out_decided      (out_decided)
  );

  always #4 clk = ~clk;

  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Verdict for one request under the given register values. The mixed branch is
  // the Hull-Dobell test; the prime loop does not stop early, only the answer matters.
  function automatic verdict_t judge_lcg(logic kind, bit [CFG_W-1:0] a, bit [CFG_W-1:0] c,
                                         bit [CFG_W-1:0] m, bit [CFG_W-1:0] x0);
    verdict_t        v;
    longint unsigned rest;
    longint unsigned p;
    v.full_period = 1'b0;
    v.decided     = 1'b1;
    if (kind == KIND_MIXED) begin
      if (m != 0 && gcd64(c, m) == 1) begin
        v.full_period = 1'b1;
        rest = m;
        p    = 2;
        while (p <= rest / p) begin
          if (rest % p == 0) begin
            if (a % p != 1) v.full_period = 1'b0;
            while (rest % p == 0) rest = rest / p;
          end
          p++;
        end
        if (rest > 1 && a % rest != 1) v.full_period = 1'b0;
        if (m[1:0] == 2'b00 && a[1:0] != MIX_RES_4) v.full_period = 1'b0;
      end
    end else if (m != 0 && (m & (m - 1)) == 0) begin
      v.full_period = a[0] && x0[0] && (a[2:0] == MUL_RES_A || a[2:0] == MUL_RES_B);
    end else begin
      v.decided = 1'b0;
    end
    return v;
  endfunction

  // Idle length for either side: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, bit [CFG_W-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_addr    <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
  endtask

  // Writes all four registers on consecutive edges. Only called with the block idle,
  // so the local copy can be updated at once.
  task automatic write_settings(bit [CFG_W-1:0] a, bit [CFG_W-1:0] c, bit [CFG_W-1:0] m,
                                bit [CFG_W-1:0] x0);
    write_reg(REG_MULTIPLIER, a);
    write_reg(REG_INCREMENT, c);
    write_reg(REG_MODULUS, m);
    write_reg(REG_SEED, x0);
    cfg_wr_en <= 1'b0;
    cur_mult  = a;
    cur_incr  = c;
    cur_mod   = m;
    cur_seed  = x0;
    settings_used++;
  endtask

  // Stops the request side and waits until every owed verdict has been transferred.
  // Spare cycles then follow so the sequencer is surely back at rest.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (verdicts_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One request transfer. Valid is only dropped when a gap is taken, so a request
  // that follows directly keeps valid high across the edge with a single assignment.
  task automatic send_request(logic kind, bit typed, verdict_t typed_v);
    int       gap;
    verdict_t owed;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_generator_kind <= kind;
    do @(posedge clk); while (!in_ready);
    // The registers cannot change while a request is in flight, so the verdict is
    // fixed at the moment of the transfer.
    owed = typed ? typed_v : judge_lcg(kind, cur_mult, cur_incr, cur_mod, cur_seed);
    verdicts_pending.insert(verdicts_pending.size(), owed);
    requests_sent++;
    if (kind == KIND_MIXED) mixed_sent++;
  endtask

  // Result side back-pressure: runs of ready broken by stalls of random length.
  int ready_left = 0;
  always @(posedge clk) begin : ready_pattern
    int stall;
    if (ready_left != 0) begin
      ready_left--;
    end else if (out_ready) begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready  <= 1'b0;
        ready_left = stall - 1;
      end else begin
        ready_left = $urandom_range(0, 7);
      end
    end else begin
      out_ready  <= 1'b1;
      ready_left = $urandom_range(0, 7);
    end
  end

  // Every result transfer is matched against the oldest owed verdict. Signals are
  // read right after the edge, before any register of the block has updated.
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_pending.size() == 0) begin
        $error("result transfer with no request outstanding: full_period=%0b decided=%0b",
               out_full_period, out_decided);
        failures++;
      end else begin
        want = verdicts_pending.pop_front();
        if (out_full_period !== want.full_period) begin
          $error("full_period mismatch: expected %0b, actual %0b",
                 want.full_period, out_full_period);
          failures++;
        end
        if (out_decided !== want.decided) begin
          $error("decided mismatch: expected %0b, actual %0b", want.decided, out_decided);
          failures++;
        end
        if (want.full_period) full_seen++;
        if (!want.decided) undecided_seen++;
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d verdicts still owed",
               quiet_cycles, verdicts_pending.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    bit [CFG_W-1:0]  a;
    bit [CFG_W-1:0]  c;
    bit [CFG_W-1:0]  m;
    bit [CFG_W-1:0]  x0;
    longint unsigned rad;
    longint unsigned rest;
    longint unsigned p;
    logic            home_kind;
    logic            kind;
    bit              mixed_safe;
    int              plan;
    int              batch;
    int              random_base;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes, both generator kinds and each special case.
    for (int i = 0; i < $size(DIRECTED); i++) begin
      if (DIRECTED[i].wr) begin
        wait_idle();
        write_settings(DIRECTED[i].mult, DIRECTED[i].incr, DIRECTED[i].modv,
                       DIRECTED[i].seedv);
      end
      send_request(DIRECTED[i].kind, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random part. Each phase waits for the block to drain, writes a fresh setting and
    // sends a short batch against it. Most settings are built to pass (or nearly pass)
    // the test of their kind, so the later stages of the check are reached often.
    // Mixed moduli are mostly a small cofactor shifted left: the high bits get exercised while
    // trial division stays short. A random modulus is only paired with multiplicative
    // requests, where no division takes place.
    random_base = requests_sent;
    while (requests_sent - random_base < RANDOM_REQUESTS) begin
      wait_idle();
      steady     = ($urandom_range(0, 4) == 0);
      plan       = $urandom_range(0, 9);
      mixed_safe = 1'b1;
      x0         = $urandom;
      if (plan < 6) begin
        home_kind = KIND_MIXED;
        case ($urandom_range(0, 19))
          0:       m = 32'd0;
          1:       m = 32'd1;
          2:       m = 32'hFFFF_FFFF;
          default: m = 32'($urandom_range(1, 1023)) << $urandom_range(0, 31);
        endcase
        // Product of the distinct primes of the modulus, doubled when 4 must divide
        // the multiplier minus one; any multiple of it plus one passes that part.
        rad  = 1;
        rest = m;
        p    = 2;
        if (m != 0) begin
          while (p <= rest / p) begin
            if (rest % p == 0) begin
              rad = rad * p;
              while (rest % p == 0) rest = rest / p;
            end
            p++;
          end
          if (rest > 1) rad = rad * rest;
          if (m[1:0] == 2'b00 && rad % 4 != 0) rad = rad * 2;
        end
        a = 32'(64'd1 + 64'($urandom_range(0, 32'(64'hFFFF_FFFF / rad))) * rad);
        if ($urandom_range(0, 3) == 0) a = $urandom;
        c = $urandom;
        if ($urandom_range(0, 4) != 0) begin
          for (int t = 0; t < 32 && gcd64(c, m) != 1; t++) c = $urandom;
        end
        if ($urandom_range(0, 9) == 0) c = 32'd0;
      end else if (plan < 9) begin
        home_kind = KIND_MULT;
        if ($urandom_range(0, 3) != 0) begin
          m = 32'd1 << $urandom_range(0, 31);
        end else begin
          m          = $urandom;
          mixed_safe = 1'b0;
        end
        a = $urandom;
        if ($urandom_range(0, 3) != 0) a[2:0] = $urandom_range(0, 1) ? MUL_RES_A : MUL_RES_B;
        if ($urandom_range(0, 3) != 0) x0[0] = 1'b1;
        c = $urandom;
      end else begin
        // Noise: arbitrary multiplier, increment and seed.
        home_kind = 1'($urandom_range(0, 1));
        m         = 32'($urandom_range(1, 1023)) << $urandom_range(0, 31);
        a         = $urandom;
        c         = $urandom;
      end
      write_settings(a, c, m, x0);
      batch = $urandom_range(1, 10);
      for (int i = 0; i < batch; i++) begin
        kind = home_kind;
        if (mixed_safe && $urandom_range(0, 3) == 0) kind = ~home_kind;
        send_request(kind, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d mixed, %0d multiplicative) over %0d register settings.",
             requests_sent, mixed_sent, requests_sent - mixed_sent, settings_used);
    $display("Verdicts: %0d full period, %0d undecided; %0d mismatches reported.",
             full_seen, undecided_seen, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
